>>> hdl/charlieplex_diag_sweep_defines.svh
// Assertion macros shared by the charlieplex diagnostic sweep RTL.
`ifndef CHARLIEPLEX_DIAG_SWEEP_DEFINES_SVH
`define CHARLIEPLEX_DIAG_SWEEP_DEFINES_SVH

`ifndef SYNTHESIS
`define CDS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("cds assertion failed");
`define CDS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cds assertion failed");
`else
`define CDS_ASSERT(lbl, clk, rst, prop)
`define CDS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> hdl/cds_pkg.sv
// Types and constants for the charlieplex diagnostic sweep.
`default_nettype none

package cds_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int MASK_W     = 26;
   localparam int ANODE_W    = 5;
   localparam int PHASE_W    = 3;
   localparam int IDX_VIEW_W = 7;

   typedef enum logic [PHASE_W-1:0] {
      PH_MARK = 3'd0,
      PH_MGAP = 3'd1,
      PH_LEAD = 3'd2,
      PH_STEP = 3'd3,
      PH_SGAP = 3'd4
   } phase_type;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SLOT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MARK_SLOT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_FRAMES = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MARK_FRAMES = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP         = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAD_DARK   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FLASH_COUNT = 3'd6;

   localparam logic [15:0] RST_STEP_SLOT   = 16'd200;
   localparam logic [15:0] RST_MARK_SLOT   = 16'd40;
   localparam logic [15:0] RST_STEP_FRAMES = 16'd600;
   localparam logic [15:0] RST_MARK_FRAMES = 16'd30;
   localparam logic [23:0] RST_GAP         = 24'd250000;
   localparam logic [23:0] RST_LEAD_DARK   = 24'd1000000;
   localparam logic [3:0]  RST_FLASH_COUNT = 4'd3;

   typedef struct packed {
      logic [15:0] step_slot_ticks;
      logic [15:0] mark_slot_ticks;
      logic [15:0] step_frames;
      logic [15:0] mark_frames;
      logic [23:0] gap_ticks;
      logic [23:0] lead_dark_ticks;
      logic [3:0]  flash_count;
   } cfg_type;

   typedef struct packed {
      phase_type              phase;
      logic [IDX_VIEW_W-1:0]  anode;
      logic [IDX_VIEW_W-1:0]  cathode;
      logic                   cycle_begin;
   } status_type;

endpackage

`default_nettype wire

>>> hdl/charlieplex_diag_sweep.sv
// Top level of the charlieplex diagnostic sweep sequencer.
`default_nettype none
`include "charlieplex_diag_sweep_defines.svh"

// One request per clock: each accepted request reports the pin drive for the
// current microsecond and, when req_tick is set, steps the sequencer by one
// tick. The result is registered in the output register upon acceptance;
// req_stall rises only while that register holds a result and rsp_stall is
// high, so with an open output side the block takes a request every cycle.
// Configuration writes through csr_* take effect from the next request.

module charlieplex_diag_sweep #(
   parameter int NUM_PINS = 26
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [cds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [cds_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic                            req_tick,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic [cds_pkg::MASK_W-1:0]      rsp_drive_high,
   output      logic [cds_pkg::MASK_W-1:0]      rsp_drive_low,
   output      logic [cds_pkg::PHASE_W-1:0]     rsp_phase_code,
   output      logic [cds_pkg::ANODE_W-1:0]     rsp_anode_now,
   output      logic                            rsp_cycle_begin
);

   cds_pkg::cfg_type    cfg;
   cds_pkg::status_type status;

   logic req_accept;
   logic lit;
   logic [cds_pkg::MASK_W-1:0] high_mask, low_mask;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cds_pkg::MASK_W-1:0]    high_ff, low_ff;
   logic [cds_pkg::PHASE_W-1:0]   phase_ff;
   logic [cds_pkg::ANODE_W-1:0]   anode_ff;
   logic                          begin_ff;

   cds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cds_seq #(
      .NUM_PINS (NUM_PINS)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (req_accept && req_tick),
      .cfg     (cfg),
      .status  (status)
   );

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      lit = (status.phase == cds_pkg::PH_MARK) || (status.phase == cds_pkg::PH_STEP);
      for (int i = 0; i < cds_pkg::MASK_W; i++) begin
         high_mask[i] = lit && (status.anode == cds_pkg::IDX_VIEW_W'(i));
         low_mask[i]  = lit && (status.cathode == cds_pkg::IDX_VIEW_W'(i));
      end
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         high_ff  <= high_mask;
         low_ff   <= low_mask;
         phase_ff <= status.phase;
         anode_ff <= status.anode[cds_pkg::ANODE_W-1:0];
         begin_ff <= status.cycle_begin;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_high  = high_ff;
   assign rsp_drive_low   = low_ff;
   assign rsp_phase_code  = phase_ff;
   assign rsp_anode_now   = anode_ff;
   assign rsp_cycle_begin = begin_ff;

   `CDS_ASSERT_NEXT(a_accept_fills, clock, reset, req_accept, rsp_valid_ff)
   `CDS_ASSERT_NEXT(a_drain_empties, clock, reset,
      rsp_valid_ff && !rsp_stall && !req_accept, !rsp_valid_ff)
   `CDS_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff)

endmodule

`default_nettype wire

>>> hdl/cds_csr.sv
// Configuration registers of the charlieplex diagnostic sweep.
`default_nettype none

module cds_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [cds_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [cds_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output cds_pkg::cfg_type                       cfg
);

   cds_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            cds_pkg::CSR_STEP_SLOT:   cfg_in.step_slot_ticks = csr_wdata[15:0];
            cds_pkg::CSR_MARK_SLOT:   cfg_in.mark_slot_ticks = csr_wdata[15:0];
            cds_pkg::CSR_STEP_FRAMES: cfg_in.step_frames     = csr_wdata[15:0];
            cds_pkg::CSR_MARK_FRAMES: cfg_in.mark_frames     = csr_wdata[15:0];
            cds_pkg::CSR_GAP:         cfg_in.gap_ticks       = csr_wdata[23:0];
            cds_pkg::CSR_LEAD_DARK:   cfg_in.lead_dark_ticks = csr_wdata[23:0];
            cds_pkg::CSR_FLASH_COUNT: cfg_in.flash_count     = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_slot_ticks <= cds_pkg::RST_STEP_SLOT;
         cfg_ff.mark_slot_ticks <= cds_pkg::RST_MARK_SLOT;
         cfg_ff.step_frames     <= cds_pkg::RST_STEP_FRAMES;
         cfg_ff.mark_frames     <= cds_pkg::RST_MARK_FRAMES;
         cfg_ff.gap_ticks       <= cds_pkg::RST_GAP;
         cfg_ff.lead_dark_ticks <= cds_pkg::RST_LEAD_DARK;
         cfg_ff.flash_count     <= cds_pkg::RST_FLASH_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> hdl/cds_seq.sv
// Sweep sequencer: phase, flash, anode/cathode and timer state, advanced per tick.
`default_nettype none
`include "charlieplex_diag_sweep_defines.svh"

module cds_seq #(
   parameter int NUM_PINS = 26
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire cds_pkg::cfg_type cfg,
   output cds_pkg::status_type status
);

   localparam int IW = $clog2(NUM_PINS + 1);
   localparam logic [IW:0]   PIN_COUNT = (IW+1)'(NUM_PINS);
   localparam logic [IW-1:0] IDX_ZERO  = '0;
   localparam logic [IW-1:0] IDX_ONE   = IW'(1);

   cds_pkg::phase_type phase_ff, phase_in;
   logic [3:0]    flash_ff, flash_in;
   logic [IW-1:0] anode_ff, anode_in;
   logic [IW-1:0] cathode_ff, cathode_in;
   logic [15:0]   slot_ff, slot_in;
   logic [15:0]   frame_ff, frame_in;
   logic [23:0]   dark_ff, dark_in;

   logic [15:0] mark_slot_lim, step_slot_lim, mark_frames_lim;
   logic [3:0]  flash_lim;
   logic [16:0] slot_inc, frame_inc;
   logic [24:0] dark_inc;
   logic [4:0]  flash_inc;
   logic [IW:0] cath_step, cath_next, anode_inc, step_target;
   logic        cath_done, anode_wrap;

   // entering a step (zero-length steps fold back to the marker)
   logic               es_start;
   cds_pkg::phase_type es_phase;
   logic [IW-1:0]      es_anode, es_cathode;

   // end of a marker gap
   logic               amg_last;
   cds_pkg::phase_type amg_phase;
   logic [IW-1:0]      amg_anode, amg_cathode;
   logic [3:0]         amg_flash;

   always_comb begin
      mark_slot_lim   = (cfg.mark_slot_ticks == '0) ? 16'd1 : cfg.mark_slot_ticks;
      step_slot_lim   = (cfg.step_slot_ticks == '0) ? 16'd1 : cfg.step_slot_ticks;
      mark_frames_lim = (cfg.mark_frames == '0) ? 16'd1 : cfg.mark_frames;
      flash_lim       = (cfg.flash_count == '0) ? 4'd1 : cfg.flash_count;

      slot_inc  = {1'b0, slot_ff} + 17'd1;
      frame_inc = {1'b0, frame_ff} + 17'd1;
      dark_inc  = {1'b0, dark_ff} + 25'd1;
      flash_inc = {1'b0, flash_ff} + 5'd1;

      cath_step  = {1'b0, cathode_ff} + (IW+1)'(1);
      cath_next  = (cath_step == {1'b0, anode_ff}) ? cath_step + (IW+1)'(1) : cath_step;
      cath_done  = cath_next >= PIN_COUNT;
      anode_inc  = {1'b0, anode_ff} + (IW+1)'(1);
      anode_wrap = anode_inc >= PIN_COUNT;

      step_target = (phase_ff == cds_pkg::PH_STEP || phase_ff == cds_pkg::PH_SGAP) ?
                    anode_inc : '0;
      es_start    = (step_target >= PIN_COUNT) ||
                    (cfg.step_frames == '0 && cfg.gap_ticks == '0);
      es_phase    = es_start ? cds_pkg::PH_MARK :
                    (cfg.step_frames != '0) ? cds_pkg::PH_STEP : cds_pkg::PH_SGAP;
      es_anode    = es_start ? IDX_ZERO : step_target[IW-1:0];
      es_cathode  = (es_start || step_target == '0) ? IDX_ONE : IDX_ZERO;

      amg_last    = flash_inc >= {1'b0, flash_lim};
      amg_flash   = amg_last ? 4'd0 : flash_inc[3:0];
      if (!amg_last) begin
         amg_phase   = cds_pkg::PH_MARK;
         amg_anode   = IDX_ZERO;
         amg_cathode = IDX_ONE;
      end else if (cfg.lead_dark_ticks != '0) begin
         amg_phase   = cds_pkg::PH_LEAD;
         amg_anode   = IDX_ZERO;
         amg_cathode = IDX_ONE;
      end else begin
         amg_phase   = es_phase;
         amg_anode   = es_anode;
         amg_cathode = es_cathode;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      flash_in   = flash_ff;
      anode_in   = anode_ff;
      cathode_in = cathode_ff;
      slot_in    = slot_ff;
      frame_in   = frame_ff;
      dark_in    = dark_ff;
      if (advance) begin
         case (phase_ff)
            cds_pkg::PH_MARK: begin
               slot_in = slot_inc[15:0];
               if (slot_inc >= {1'b0, mark_slot_lim}) begin
                  slot_in = '0;
                  if (!cath_done) begin
                     cathode_in = cath_next[IW-1:0];
                  end else if (!anode_wrap) begin
                     anode_in   = anode_inc[IW-1:0];
                     cathode_in = IDX_ZERO;
                  end else if (frame_inc < {1'b0, mark_frames_lim}) begin
                     anode_in   = IDX_ZERO;
                     cathode_in = IDX_ONE;
                     frame_in   = frame_inc[15:0];
                  end else begin
                     frame_in = '0;
                     dark_in  = '0;
                     if (cfg.gap_ticks != '0) begin
                        phase_in   = cds_pkg::PH_MGAP;
                        anode_in   = IDX_ZERO;
                        cathode_in = IDX_ONE;
                     end else begin
                        phase_in   = amg_phase;
                        flash_in   = amg_flash;
                        anode_in   = amg_anode;
                        cathode_in = amg_cathode;
                     end
                  end
               end
            end
            cds_pkg::PH_MGAP: begin
               if (dark_inc >= {1'b0, cfg.gap_ticks}) begin
                  phase_in   = amg_phase;
                  flash_in   = amg_flash;
                  anode_in   = amg_anode;
                  cathode_in = amg_cathode;
                  slot_in    = '0;
                  frame_in   = '0;
                  dark_in    = '0;
               end else begin
                  dark_in = dark_inc[23:0];
               end
            end
            cds_pkg::PH_LEAD: begin
               if (dark_inc >= {1'b0, cfg.lead_dark_ticks}) begin
                  phase_in   = es_phase;
                  flash_in   = 4'd0;
                  anode_in   = es_anode;
                  cathode_in = es_cathode;
                  slot_in    = '0;
                  frame_in   = '0;
                  dark_in    = '0;
               end else begin
                  dark_in = dark_inc[23:0];
               end
            end
            cds_pkg::PH_STEP: begin
               slot_in = slot_inc[15:0];
               if (slot_inc >= {1'b0, step_slot_lim}) begin
                  slot_in = '0;
                  if (!cath_done) begin
                     cathode_in = cath_next[IW-1:0];
                  end else begin
                     cathode_in = (anode_ff == IDX_ZERO) ? IDX_ONE : IDX_ZERO;
                     if (frame_inc < {1'b0, cfg.step_frames}) begin
                        frame_in = frame_inc[15:0];
                     end else begin
                        frame_in = '0;
                        dark_in  = '0;
                        if (cfg.gap_ticks != '0) begin
                           phase_in = cds_pkg::PH_SGAP;
                        end else begin
                           phase_in   = es_phase;
                           flash_in   = 4'd0;
                           anode_in   = es_anode;
                           cathode_in = es_cathode;
                        end
                     end
                  end
               end
            end
            cds_pkg::PH_SGAP: begin
               if (dark_inc >= {1'b0, cfg.gap_ticks}) begin
                  phase_in   = es_phase;
                  flash_in   = 4'd0;
                  anode_in   = es_anode;
                  cathode_in = es_cathode;
                  slot_in    = '0;
                  frame_in   = '0;
                  dark_in    = '0;
               end else begin
                  dark_in = dark_inc[23:0];
               end
            end
            default: begin
               phase_in   = cds_pkg::PH_MARK;
               flash_in   = 4'd0;
               anode_in   = IDX_ZERO;
               cathode_in = IDX_ONE;
               slot_in    = '0;
               frame_in   = '0;
               dark_in    = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= cds_pkg::PH_MARK;
         flash_ff   <= 4'd0;
         anode_ff   <= IDX_ZERO;
         cathode_ff <= IDX_ONE;
         slot_ff    <= '0;
         frame_ff   <= '0;
         dark_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         flash_ff   <= flash_in;
         anode_ff   <= anode_in;
         cathode_ff <= cathode_in;
         slot_ff    <= slot_in;
         frame_ff   <= frame_in;
         dark_ff    <= dark_in;
      end
   end

   assign status.phase       = phase_ff;
   assign status.anode       = cds_pkg::IDX_VIEW_W'(anode_ff);
   assign status.cathode     = cds_pkg::IDX_VIEW_W'(cathode_ff);
   assign status.cycle_begin = (phase_ff == cds_pkg::PH_MARK) && (flash_ff == 4'd0) &&
                               (anode_ff == IDX_ZERO) && (cathode_ff == IDX_ONE) &&
                               (slot_ff == '0) && (frame_ff == '0);

   `CDS_ASSERT(a_pins_in_range, clock, reset,
      ({1'b0, anode_ff} < PIN_COUNT) && ({1'b0, cathode_ff} < PIN_COUNT))
   `CDS_ASSERT(a_cathode_not_anode, clock, reset, cathode_ff != anode_ff)
   `CDS_ASSERT(a_dark_anode_zero, clock, reset,
      (phase_ff != cds_pkg::PH_MGAP && phase_ff != cds_pkg::PH_LEAD) || anode_ff == IDX_ZERO)

endmodule

`default_nettype wire
